// ===== hdl/ssr_pkg.sv =====
// Shared types and constants for the Solovay-Strassen round block.
package ssr_pkg;

   localparam int WIDTH = 32;

   typedef logic [WIDTH-1:0] word_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_START,
      ST_RED_WAIT,
      ST_JAC_CHECK,
      ST_JAC_SWAP,
      ST_POW_SETUP,
      ST_POW_BIT,
      ST_POW_MUL_WAIT,
      ST_POW_SQ_WAIT,
      ST_DONE
   } state_type;

   typedef enum logic [0:0] {
      OP_MOD,
      OP_MUL
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_ctl_type;

endpackage

// ===== hdl/ssr_arith.sv =====
// Shared bit-serial unit: y mod n, or x*y mod n by shift-and-add.
module ssr_arith (
   input  logic                  clock,
   input  logic                  reset,
   input  ssr_pkg::unit_ctl_type ctl,
   input  ssr_pkg::word_type     x,
   input  ssr_pkg::word_type     y,
   input  ssr_pkg::word_type     n,
   output logic                  done,
   output ssr_pkg::word_type     result
);
   import ssr_pkg::*;

   localparam int CW = $clog2(WIDTH + 1);

   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   op_type        op_ff, op_in;
   word_type      r_ff, r_in;
   word_type      x_ff, x_in;
   word_type      y_ff, y_in;
   word_type      n_ff, n_in;
   logic          done_ff, done_in;

   logic [WIDTH:0] dbl;
   word_type       r1;
   logic [WIDTH:0] sum;
   word_type       r2;

   always_comb begin
      dbl = {r_ff, 1'b0};
      if (op_ff == OP_MOD) begin
         dbl[0] = y_ff[WIDTH-1];
      end
      r1 = (dbl >= {1'b0, n_ff}) ? word_type'(dbl - {1'b0, n_ff}) : dbl[WIDTH-1:0];
      sum = {1'b0, r1} + {1'b0, x_ff};
      if (op_ff == OP_MUL && y_ff[WIDTH-1]) begin
         r2 = (sum >= {1'b0, n_ff}) ? word_type'(sum - {1'b0, n_ff}) : sum[WIDTH-1:0];
      end else begin
         r2 = r1;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      r_in    = r_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      n_in    = n_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         r_in   = r2;
         y_in   = {y_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctl.start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH);
         op_in   = ctl.op;
         r_in    = '0;
         x_in    = x;
         y_in    = y;
         n_in    = n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      op_ff <= op_in;
      r_ff  <= r_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      n_ff  <= n_in;
   end

   assign done   = done_ff;
   assign result = r_ff;

endmodule

// ===== hdl/solovay_strassen_round.sv =====
// Top level: one Solovay-Strassen round on the configured modulus.
// Work: modular reductions in the Jacobi loop, plus
// up to 2*WIDTH modular multiplies in the power step.
// Throughput: one transaction at a time; all arithmetic runs through one
// shared bit-serial mod/multiply unit. Moduli below three, and even moduli, skip it.
// Reset (synchronous, active high) clears the modulus and the sequencer.
module solovay_strassen_round (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [31:0]               csr_modulus,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [31:0]               req_witness,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_verdict,
   output logic signed [1:0]         rsp_jacobi_symbol,
   output logic [31:0]               rsp_power_value
);
   import ssr_pkg::*;

   state_type     state_ff, state_in;
   word_type      mod_ff, mod_in;
   word_type      a_ff, a_in;
   word_type      b_ff, b_in;
   word_type      acc_ff, acc_in;
   word_type      sq_ff, sq_in;
   word_type      e_ff, e_in;
   logic          neg_ff, neg_in;
   logic          pass_ff, pass_in;
   logic [1:0]    jac_ff, jac_in;
   logic          rv_ff, rv_in;

   unit_ctl_type  ctl;
   word_type      ux, uy;
   logic          udone;
   word_type      ures;

   ssr_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .x      (ux),
      .y      (uy),
      .n      (b_ff),
      .done   (udone),
      .result (ures)
   );

   assign csr_ready = (state_ff == ST_IDLE) && !rv_ff;
   assign req_stall = (state_ff != ST_IDLE) || rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mod_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         mod_ff   <= mod_in;
         rv_ff    <= rv_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      sq_ff   <= sq_in;
      e_ff    <= e_in;
      neg_ff  <= neg_in;
      pass_ff <= pass_in;
      jac_ff  <= jac_in;
   end

   always_comb begin
      state_in = state_ff;
      mod_in   = mod_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      acc_in   = acc_ff;
      sq_in    = sq_ff;
      e_in     = e_ff;
      neg_in   = neg_ff;
      pass_in  = pass_ff;
      jac_in   = jac_ff;
      rv_in    = rv_ff;
      ctl.start = 1'b0;
      ctl.op    = OP_MOD;
      ux = '0;
      uy = a_ff;

      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      if (csr_valid && csr_ready) begin
         mod_in = word_type'(csr_modulus);
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall) begin
               a_in    = word_type'(req_witness);
               b_in    = mod_ff;
               neg_in  = 1'b0;
               pass_in = 1'b0;
               jac_in  = 2'd0;
               acc_in  = '0;
               if (mod_ff == word_type'(2)) begin
                  pass_in  = 1'b1;
                  state_in = ST_DONE;
               end else if (mod_ff < word_type'(3) || !mod_ff[0]) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_RED_START;
               end
            end
         end
         ST_RED_START: begin
            ctl.start = 1'b1;
            ctl.op    = OP_MOD;
            state_in  = ST_RED_WAIT;
         end
         ST_RED_WAIT: begin
            if (udone) begin
               a_in = ures;
               if (b_ff == mod_ff && sq_ff != ures) begin
                  sq_in = ures;
               end
               if (b_ff == mod_ff) begin
                  sq_in = ures;
               end
               state_in = ST_JAC_CHECK;
            end
         end
         ST_JAC_CHECK: begin
            if (a_ff == '0) begin
               jac_in   = 2'd0;
               state_in = ST_DONE;
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
               if (b_ff[2:0] == 3'd3 || b_ff[2:0] == 3'd5) begin
                  neg_in = !neg_ff;
               end
            end else if (a_ff == word_type'(1)) begin
               jac_in   = neg_ff ? 2'b11 : 2'b01;
               state_in = ST_POW_SETUP;
            end else begin
               if (a_ff[1:0] == 2'd3 && b_ff[1:0] == 2'd3) begin
                  neg_in = !neg_ff;
               end
               state_in = ST_JAC_SWAP;
            end
         end
         ST_JAC_SWAP: begin
            a_in = b_ff;
            b_in = a_ff;
            state_in = (b_ff >= a_ff) ? ST_RED_START : ST_JAC_CHECK;
         end
         ST_POW_SETUP: begin
            b_in     = mod_ff;
            acc_in   = word_type'(1);
            e_in     = (mod_ff - word_type'(1)) >> 1;
            state_in = ST_POW_BIT;
         end
         ST_POW_BIT: begin
            if (e_ff == '0) begin
               if (jac_ff == 2'b01) begin
                  pass_in = (acc_ff == word_type'(1));
               end else begin
                  pass_in = (acc_ff == (mod_ff - word_type'(1)));
               end
               state_in = ST_DONE;
            end else if (e_ff[0]) begin
               ctl.start = 1'b1;
               ctl.op    = OP_MUL;
               ux = acc_ff;
               uy = sq_ff;
               state_in = ST_POW_MUL_WAIT;
            end else begin
               ctl.start = 1'b1;
               ctl.op    = OP_MUL;
               ux = sq_ff;
               uy = sq_ff;
               state_in = ST_POW_SQ_WAIT;
            end
         end
         ST_POW_MUL_WAIT: begin
            if (udone) begin
               acc_in   = ures;
               e_in     = {e_ff[WIDTH-1:1], 1'b0};
               state_in = ST_POW_BIT;
            end
         end
         ST_POW_SQ_WAIT: begin
            if (udone) begin
               sq_in    = ures;
               e_in     = e_ff >> 1;
               state_in = ST_POW_BIT;
            end
         end
         ST_DONE: begin
            if (!rv_ff) begin
               rv_in    = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid         = rv_ff;
   assign rsp_verdict       = pass_ff;
   assign rsp_jacobi_symbol = jac_ff;
   assign rsp_power_value   = 32'(acc_ff);

endmodule
